>>> rtl/rped_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rped_pkg;

  localparam int PrimeBits = 16;
  localparam int WordBits  = 32;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadExp = 2'd1;
  localparam logic [1:0] StatusNoKey  = 2'd2;

  // request to the shared divider
  typedef struct packed {
    logic                  start;
    logic                  long_mode;
    logic [2*WordBits-1:0] dividend;
    logic [WordBits-1:0]   divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic                done;
    logic [WordBits-1:0] quotient;
    logic [WordBits-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/rped_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rped_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rped_pkg::div_req_t req_i,
  output rped_pkg::div_rsp_t rsp_o
);
  import rped_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [6:0]            cnt_q;
  logic [WordBits-1:0]   rem_q;
  logic [WordBits-1:0]   dvs_q;
  logic [2*WordBits-1:0] quo_q;

  logic [WordBits:0]   trial;
  logic [WordBits:0]   diff;
  logic                ge;
  logic [WordBits-1:0] rem_nxt;

  // one restoring step per cycle
  always_comb begin
    trial   = {rem_q, quo_q[2*WordBits-1]};
    diff    = trial - {1'b0, dvs_q};
    ge      = trial >= {1'b0, dvs_q};
    rem_nxt = ge ? diff[WordBits-1:0] : trial[WordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.long_mode ? 7'd64 : 7'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.long_mode ? req_i.dividend
                               : {req_i.dividend[WordBits-1:0], {WordBits{1'b0}}};
    end else if (busy_q) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[2*WordBits-2:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q[WordBits-1:0];
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

>>> rtl/rsa_private_exponent_derivation.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: form n and phi and range check e, then gcd steps, the lambda division,
//   euclid steps and modular checks, then hand out the result item; the time from
//   input item to result item is data dependent
// throughput: one item at a time; the shared 1-bit-per-cycle divider sets the figure
// reset: asynchronous active low, returns to idle with no result pending
module rsa_private_exponent_derivation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rped_pkg::PrimeBits-1:0]     prime_p_i,
  input  logic [rped_pkg::PrimeBits-1:0]     prime_q_i,
  input  logic [rped_pkg::WordBits-1:0]      public_exp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rped_pkg::WordBits-1:0]      modulus_o,
  output logic [rped_pkg::WordBits-1:0]      private_exp_o,
  output logic [1:0]                         status_o
);
  import rped_pkg::*;

  typedef enum logic [13:0] {
    StIdle    = 14'b00000000000001,
    StMulN    = 14'b00000000000010,
    StMulPhi  = 14'b00000000000100,
    StCheck   = 14'b00000000001000,
    StGcdTst  = 14'b00000000010000,
    StGcdWait = 14'b00000000100000,
    StLamWait = 14'b00000001000000,
    StLamMul  = 14'b00000010000000,
    StEuTst   = 14'b00000100000000,
    StEuWait  = 14'b00001000000000,
    StEuMul   = 14'b00010000000000,
    StMmMul   = 14'b00100000000000,
    StMmWait  = 14'b01000000000000,
    StDone    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // operands and working registers
  logic [PrimeBits-1:0] p_q, q_q, pm_q, qm_q;
  logic [WordBits-1:0]  e_q, n_q, phi_q, lam_q, m_q;
  logic [WordBits-1:0]  a_q, b_q;          // plain gcd pair
  logic [WordBits-1:0]  ro_q, rc_q;        // euclid remainders
  logic [WordBits-1:0]  so_q, sc_q;        // coefficient magnitudes
  logic [WordBits-1:0]  qt_q, dc_q, d1_q, d_q;
  logic                 gcd_ph_q;          // 0: gcd(e,phi), 1: gcd(p-1,q-1)
  logic                 cand_q;            // 0: against phi, 1: against lambda
  logic                 v1_q;
  logic [1:0]           status_q;

  // divider request registers
  logic                  div_start_q;
  logic                  div_long_q;
  logic [2*WordBits-1:0] div_dvd_q;
  logic [WordBits-1:0]   div_dvs_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [WordBits-1:0]   mul_a, mul_b, dcand;
  logic [2*WordBits-1:0] prod;
  logic                  in_acc, e_bad, v2;

  assign div_req = '{start: div_start_q, long_mode: div_long_q,
                     dividend: div_dvd_q, divisor: div_dvs_q};

  rped_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign in_acc      = in_valid_i && in_ready_o;

  // e must lie strictly between one and phi
  assign e_bad = (e_q <= 32'd1) || (e_q >= phi_q);
  // coefficient above the modulus gives a zero candidate
  assign dcand = (so_q > m_q) ? '0 : (m_q - so_q);
  assign v2    = (div_rsp.remainder == 32'd1);

  // the one shared multiplier, operands picked by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMulN:   begin mul_a = WordBits'(p_q); mul_b = WordBits'(q_q);  end
      StMulPhi: begin mul_a = WordBits'(pm_q); mul_b = WordBits'(qm_q); end
      StLamMul: begin mul_a = qt_q; mul_b = WordBits'(qm_q); end
      StEuMul:  begin mul_a = qt_q; mul_b = sc_q; end
      StMmMul:  begin mul_a = dc_q; mul_b = e_q; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_acc) state_d = StMulN;
      StMulN:    state_d = StMulPhi;
      StMulPhi:  state_d = StCheck;
      StCheck:   state_d = e_bad ? StDone : StGcdTst;
      StGcdTst: begin
        if (b_q != '0) begin
          state_d = StGcdWait;
        end else if (gcd_ph_q) begin
          state_d = StLamWait;
        end else begin
          state_d = (a_q == 32'd1) ? StGcdTst : StDone;
        end
      end
      StGcdWait: if (div_rsp.done) state_d = StGcdTst;
      StLamWait: if (div_rsp.done) state_d = StLamMul;
      StLamMul:  state_d = StEuTst;
      StEuTst:   state_d = (rc_q == '0) ? StMmMul : StEuWait;
      StEuWait:  if (div_rsp.done) state_d = StEuMul;
      StEuMul:   state_d = StEuTst;
      StMmMul:   state_d = StMmWait;
      StMmWait:  if (div_rsp.done) state_d = cand_q ? StDone : StEuTst;
      StDone:    if (out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= ((state_q == StGcdTst) && ((b_q != '0) || gcd_ph_q))
                  || ((state_q == StEuTst) && (rc_q != '0))
                  || (state_q == StMmMul);
    end
  end

  // divider operands
  always_ff @(posedge clk_i) begin
    if (state_q == StMmMul) begin
      div_long_q <= 1'b1;
      div_dvd_q  <= prod;
      div_dvs_q  <= m_q;
    end else if (state_q == StEuTst) begin
      div_long_q <= 1'b0;
      div_dvd_q  <= {32'b0, ro_q};
      div_dvs_q  <= rc_q;
    end else if ((state_q == StGcdTst) && (b_q != '0)) begin
      div_long_q <= 1'b0;
      div_dvd_q  <= {32'b0, a_q};
      div_dvs_q  <= b_q;
    end else if (state_q == StGcdTst) begin
      // lambda: (p-1) divided by the gcd
      div_long_q <= 1'b0;
      div_dvd_q  <= (2*WordBits)'(pm_q);
      div_dvs_q  <= a_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          p_q  <= prime_p_i;
          q_q  <= prime_q_i;
          e_q  <= public_exp_i;
          pm_q <= (prime_p_i == '0) ? '0 : prime_p_i - PrimeBits'(1);
          qm_q <= (prime_q_i == '0) ? '0 : prime_q_i - PrimeBits'(1);
        end
      end
      StMulN:   n_q   <= prod[WordBits-1:0];
      StMulPhi: phi_q <= prod[WordBits-1:0];
      StCheck: begin
        status_q <= StatusBadExp;
        d_q      <= '0;
        a_q      <= e_q;
        b_q      <= phi_q;
        gcd_ph_q <= 1'b0;
      end
      StGcdTst: begin
        if ((b_q == '0) && !gcd_ph_q && (a_q == 32'd1)) begin
          a_q      <= WordBits'(pm_q);
          b_q      <= WordBits'(qm_q);
          gcd_ph_q <= 1'b1;
        end
      end
      StGcdWait: begin
        if (div_rsp.done) begin
          a_q <= b_q;
          b_q <= div_rsp.remainder;
        end
      end
      StLamWait: if (div_rsp.done) qt_q <= div_rsp.quotient;
      StLamMul: begin
        lam_q  <= prod[WordBits-1:0];
        m_q    <= phi_q;
        cand_q <= 1'b0;
        ro_q   <= e_q;
        rc_q   <= phi_q;
        so_q   <= 32'd1;
        sc_q   <= '0;
      end
      StEuTst: if (rc_q == '0) dc_q <= dcand;
      StEuWait: begin
        if (div_rsp.done) begin
          qt_q <= div_rsp.quotient;
          ro_q <= rc_q;
          rc_q <= div_rsp.remainder;
        end
      end
      StEuMul: begin
        so_q <= sc_q;
        sc_q <= so_q + prod[WordBits-1:0];
      end
      StMmWait: begin
        if (div_rsp.done) begin
          if (!cand_q) begin
            // first candidate checked, set up the run against lambda
            d1_q   <= dc_q;
            v1_q   <= v2;
            m_q    <= lam_q;
            cand_q <= 1'b1;
            ro_q   <= e_q;
            rc_q   <= lam_q;
            so_q   <= 32'd1;
            sc_q   <= '0;
          end else if (v1_q && v2) begin
            status_q <= StatusOk;
            d_q      <= (d1_q > dc_q) ? dc_q : d1_q;
          end else if (v1_q) begin
            status_q <= StatusOk;
            d_q      <= d1_q;
          end else if (v2) begin
            status_q <= StatusOk;
            d_q      <= dc_q;
          end else begin
            status_q <= StatusNoKey;
            d_q      <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign modulus_o     = n_q;
  assign private_exp_o = d_q;
  assign status_o      = status_q;

  // a rejected item never carries an exponent
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StatusOk)) |-> (private_exp_o == '0))
    else $error("rejected item with nonzero exponent");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == StatusOk) || (status_o == StatusBadExp)
                     || (status_o == StatusNoKey)))
    else $error("undefined status code");

  // divider is only started on the way into a wait state
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> ((state_q == StGcdWait) || (state_q == StLamWait)
                     || (state_q == StEuWait) || (state_q == StMmWait)))
    else $error("divider started outside a wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == StGcdWait) || (state_q == StLamWait)
                      || (state_q == StEuWait) || (state_q == StMmWait)))
    else $error("divider finished with nobody waiting");

endmodule
`default_nettype wire
